/* rtl/core/mf3x3_pkg.sv */
// Package for the 3x3 maximum filter: field widths, register indexes,
// reset values and the item kind carried down the datapath.
// No dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package mf3x3_pkg;

  // Default values for the module parameters.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  // Port field widths.
  localparam int DATA_BITS         = 16;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 16;
  localparam int FRAME_WIDTH_BITS  = 13;
  localparam int FRAME_HEIGHT_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values.
  localparam int RESET_FRAME_WIDTH  = 1920;
  localparam int RESET_FRAME_HEIGHT = 1080;

  // Input command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // What an accepted item does once its line buffer data is back.
  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_DRAIN,
    KIND_LAST
  } item_kind_t;

endpackage

/* rtl/core/mf3x3_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No package dependencies.
`timescale 1ns / 1ps

module mf3x3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/max_filter_3x3.sv */
// Top level of the 3x3 maximum filter (grayscale dilation) over a raster stream.
// Depends on mf3x3_pkg and on mf3x3_ram for the two line buffers.
//
//   Channel   Direction  Handshake              Payload
//   s_axis    in         tvalid/tready          tdata = pixel_in, tuser = cmd
//   m_axis    out        tvalid/tready          tdata = pixel_out, tlast = frame_done
//   cfg       in         cfg_we (no wait)       cfg_index, cfg_data
//
// One item is taken per cycle while s_axis_tready is high. An item reads both
// line buffers at its column in the cycle it is accepted; the next cycle combines
// the read data with the window, writes the line buffers back and pushes the
// result into a four-entry output queue, so a result is visible once queued.
// s_axis_tready drops while the queue fill plus the item in flight reaches four.
// Reset is synchronous and clears counters, window and queue; the line buffers
// are not cleared, and no entry is used before the current frame has written it.
`timescale 1ns / 1ps

module max_filter_3x3 #(
  parameter int MAX_WIDTH  = mf3x3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = mf3x3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mf3x3_pkg::DATA_BITS-1:0]      s_axis_tdata,   // [15:0] pixel_in
  input  logic                                 s_axis_tuser,   // [0] cmd
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mf3x3_pkg::DATA_BITS-1:0]      m_axis_tdata,   // [15:0] pixel_out
  output logic                                 m_axis_tlast,   // frame_done
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [mf3x3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf3x3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int XB = $clog2(MAX_WIDTH);      // column index bits
  localparam int WB = $clog2(MAX_WIDTH + 1);  // width value bits
  localparam int DB = $clog2(MAX_WIDTH + 2);  // drain count bits
  localparam int HB = mf3x3_pkg::FRAME_HEIGHT_BITS;
  localparam int RESET_W = (mf3x3_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : mf3x3_pkg::RESET_FRAME_WIDTH;
  localparam int QD = 4;                      // output queue depth
  localparam int QB = $clog2(QD);
  localparam int FRAME_WIDTH_BITS_LOCAL = mf3x3_pkg::FRAME_WIDTH_BITS;

  // Effective frame size and position counters.
  logic [WB-1:0] width_eff, width_next;
  logic [HB-1:0] height_eff, height_next;
  logic [XB-1:0] col_cnt, col_next;
  logic [HB-1:0] row_cnt, row_next;
  logic [DB-1:0] drain_left, drain_next;

  // Item in flight, waiting for line buffer data.
  logic                        s1_valid, s1_valid_next;
  mf3x3_pkg::item_kind_t       s1_kind, kind_next;
  logic                        s1_emit, emit_next;
  logic                        s1_first, s1_ge2, s1_r1, s1_r2;
  logic [PIXEL_BITS-1:0]       s1_pix;
  logic [XB-1:0]               s1_addr;

  // Window: clipped column maxima of the two newest columns.
  logic [PIXEL_BITS-1:0] win1, win2;

  // Line buffer read data.
  logic [PIXEL_BITS-1:0] above_rd, middle_rd;

  // Output queue.
  logic [PIXEL_BITS:0] q_mem [QD];
  logic [QB-1:0]       q_wr, q_rd;
  logic [QB:0]         q_cnt;
  logic                q_push, q_pop;

  logic                accept;
  logic                x_last;
  logic [HB-1:0]       row_inc;
  logic [FRAME_WIDTH_BITS_LOCAL-1:0] cfg_w_raw;
  logic [WB-1:0]       cfg_w_clamped;
  logic [HB-1:0]       cfg_h_clamped;

  // Stage-one datapath values.
  logic [PIXEL_BITS-1:0] col_pix_a, col_pix, col_drain, col_val;
  logic [PIXEL_BITS-1:0] max12, res_a, res_b, res_val;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Room for the item in flight and one more in the queue.
  assign s_axis_tready = (q_cnt + {{QB{1'b0}}, s1_valid}) <= (QB + 1)'(QD - 1);

  // Column and row stepping.
  assign x_last  = (WB'(col_cnt) + WB'(1)) == width_eff;
  assign row_inc = row_cnt + HB'(1);

  // Register values clamped to the usable range.
  assign cfg_w_raw = cfg_data[FRAME_WIDTH_BITS_LOCAL-1:0];
  always_comb begin
    if (cfg_w_raw < FRAME_WIDTH_BITS_LOCAL'(2)) begin
      cfg_w_clamped = WB'(2);
    end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
      cfg_w_clamped = WB'(MAX_WIDTH);
    end else begin
      cfg_w_clamped = WB'(cfg_w_raw);
    end
  end

  assign cfg_h_clamped = (cfg_data[HB-1:0] < HB'(2)) ? HB'(2) : cfg_data[HB-1:0];

  // Control: counters, drain count and the decision for each accepted item.
  always_comb begin
    width_next    = width_eff;
    height_next   = height_eff;
    col_next      = col_cnt;
    row_next      = row_cnt;
    drain_next    = drain_left;
    s1_valid_next = 1'b0;
    kind_next     = mf3x3_pkg::KIND_PIXEL;
    emit_next     = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        mf3x3_pkg::REG_FRAME_WIDTH: begin
          width_next = cfg_w_clamped;
          col_next   = '0;
          row_next   = '0;
          drain_next = '0;
        end
        mf3x3_pkg::REG_FRAME_HEIGHT: begin
          height_next = cfg_h_clamped;
          col_next    = '0;
          row_next    = '0;
          drain_next  = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (s_axis_tuser == mf3x3_pkg::CMD_PIXEL) begin
        // A pixel is ignored while the frame drains.
        if (drain_left == '0) begin
          s1_valid_next = 1'b1;
          kind_next     = mf3x3_pkg::KIND_PIXEL;
          emit_next     = (col_cnt == '0) ? (|row_cnt[HB-1:1]) : (row_cnt != '0);
          if (x_last) begin
            col_next = '0;
            row_next = row_inc;
            if (row_inc >= height_eff) begin
              drain_next = DB'(width_eff) + DB'(1);
            end
          end else begin
            col_next = col_cnt + XB'(1);
          end
        end
      end else if (drain_left == DB'(1)) begin
        // Last result of the frame; restart for the next one.
        s1_valid_next = 1'b1;
        kind_next     = mf3x3_pkg::KIND_LAST;
        emit_next     = 1'b1;
        col_next      = '0;
        row_next      = '0;
        drain_next    = '0;
      end else if (drain_left != '0) begin
        s1_valid_next = 1'b1;
        kind_next     = mf3x3_pkg::KIND_DRAIN;
        emit_next     = 1'b1;
        col_next      = x_last ? '0 : col_cnt + XB'(1);
        drain_next    = drain_left - DB'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WB'(RESET_W);
      height_eff <= HB'(mf3x3_pkg::RESET_FRAME_HEIGHT);
      col_cnt    <= '0;
      row_cnt    <= '0;
      drain_left <= '0;
      s1_valid   <= 1'b0;
    end else begin
      width_eff  <= width_next;
      height_eff <= height_next;
      col_cnt    <= col_next;
      row_cnt    <= row_next;
      drain_left <= drain_next;
      s1_valid   <= s1_valid_next;
    end
  end

  // Item fields carried to the second stage.
  always_ff @(posedge clk) begin
    s1_kind  <= kind_next;
    s1_emit  <= emit_next;
    s1_first <= (col_cnt == '0);
    s1_ge2   <= WB'(col_cnt) >= WB'(2);
    s1_r1    <= (row_cnt != '0);
    s1_r2    <= |row_cnt[HB-1:1];
    s1_pix   <= s_axis_tdata[PIXEL_BITS-1:0];
    s1_addr  <= col_cnt;
  end

  // Line buffers: read at the current column, written back in the following cycle.
  // Consecutive memory items always use different columns.
  mf3x3_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_above (
    .clk  (clk),
    .we   (s1_valid && (s1_kind == mf3x3_pkg::KIND_PIXEL)),
    .waddr(s1_addr),
    .wdata(middle_rd),
    .raddr(col_cnt),
    .rdata(above_rd)
  );

  mf3x3_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_middle (
    .clk  (clk),
    .we   (s1_valid && (s1_kind == mf3x3_pkg::KIND_PIXEL)),
    .waddr(s1_addr),
    .wdata(s1_pix),
    .raddr(col_cnt),
    .rdata(middle_rd)
  );

  // Column maximum, clipped at the top of the frame for pixels.
  assign col_pix_a = (s1_r1 && (middle_rd > s1_pix)) ? middle_rd : s1_pix;
  assign col_pix   = (s1_r2 && (above_rd > col_pix_a)) ? above_rd : col_pix_a;
  assign col_drain = (above_rd > middle_rd) ? above_rd : middle_rd;
  assign col_val   = (s1_kind == mf3x3_pkg::KIND_PIXEL) ? col_pix : col_drain;

  // Result over the window, clipped at the left and right edges.
  assign max12   = (win1 > win2) ? win1 : win2;
  assign res_a   = (col_val > win2) ? col_val : win2;
  assign res_b   = (s1_ge2 && (win1 > res_a)) ? win1 : res_a;
  assign res_val = (s1_first || (s1_kind == mf3x3_pkg::KIND_LAST)) ? max12 : res_b;

  // Window shift; the frame's last result leaves it as it is.
  always_ff @(posedge clk) begin
    if (rst) begin
      win1 <= '0;
      win2 <= '0;
    end else if (s1_valid && (s1_kind != mf3x3_pkg::KIND_LAST)) begin
      win1 <= win2;
      win2 <= col_val;
    end
  end

  // Output queue.
  assign q_push = s1_valid && s1_emit;
  assign q_pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= {(s1_kind == mf3x3_pkg::KIND_LAST), res_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (q_push) begin
        q_wr <= q_wr + QB'(1);
      end
      if (q_pop) begin
        q_rd <= q_rd + QB'(1);
      end
      q_cnt <= q_cnt + {{QB{1'b0}}, q_push} - {{QB{1'b0}}, q_pop};
    end
  end

  assign m_axis_tvalid = (q_cnt != '0);
  assign m_axis_tdata  = mf3x3_pkg::DATA_BITS'(q_mem[q_rd][PIXEL_BITS-1:0]);
  assign m_axis_tlast  = q_mem[q_rd][PIXEL_BITS];

endmodule

/* verif/mf3x3_checker.sv */
// Checker for the 3x3 maximum filter: watches the input, output and register
// channels, predicts every window maximum and compares it with what comes out.
// Depends on mf3x3_pkg for field widths, register indexes and command codes.
`timescale 1ns / 1ps

module mf3x3_checker #(
  parameter int MAX_WIDTH = mf3x3_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  input  logic                                 s_axis_tready,
  input  logic [mf3x3_pkg::DATA_BITS-1:0]      s_axis_tdata,   // [15:0] pixel_in
  input  logic                                 s_axis_tuser,   // [0] cmd
  input  logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic [mf3x3_pkg::DATA_BITS-1:0]      m_axis_tdata,   // [15:0] pixel_out
  input  logic                                 m_axis_tlast,   // frame_done
  input  logic                                 cfg_we,
  input  logic [mf3x3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf3x3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                   errors,
  output int                                   outstanding
);

  import mf3x3_pkg::*;

  typedef struct packed {
    logic [DATA_BITS-1:0] pixel;
    logic                 frame_done;
  } max_result_t;

  // Predicted window maxima, oldest first.
  max_result_t pending_max_q[$];

  // Shadow copy of the filter state.
  logic [FRAME_WIDTH_BITS-1:0]  width_reg;
  logic [FRAME_HEIGHT_BITS-1:0] height_reg;
  logic [DATA_BITS-1:0]         top_row [MAX_WIDTH];
  logic [DATA_BITS-1:0]         mid_row [MAX_WIDTH];
  logic [DATA_BITS-1:0]         win [3];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int unsigned                  drain_left;
  int                           err_cnt;

  function automatic logic [DATA_BITS-1:0] max16(input logic [DATA_BITS-1:0] a,
                                                 input logic [DATA_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Advances the shadow state by one accepted item and queues the window
  // maximum it releases, if any.
  function automatic void dilate_item(input logic cmd, input logic [DATA_BITS-1:0] pin);
    int unsigned          w;
    int unsigned          h;
    int unsigned          x;
    logic [DATA_BITS-1:0] colmax;
    logic [DATA_BITS-1:0] res;
    bit                   emit;
    w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < 2) ? 2 : height_reg;
    x = (col_pos >= w) ? 0 : col_pos;
    if (cmd == CMD_PIXEL) begin
      // Pixels offered while the frame drains are dropped.
      if (drain_left != 0) return;
      colmax = pin;
      if (row_pos >= 1) colmax = max16(colmax, mid_row[x]);
      if (row_pos >= 2) colmax = max16(colmax, top_row[x]);
      // The left column only completes once the row below it has started.
      emit = (x == 0) ? (row_pos >= 2) : (row_pos >= 1);
      top_row[x] = mid_row[x];
      mid_row[x] = pin;
    end else begin
      if (drain_left == 0) return;
      if (drain_left == 1) begin
        // Last result of the frame: the bottom-right corner.
        pending_max_q.push_back('{pixel: max16(win[1], win[2]), frame_done: 1'b1});
        col_pos = 0;
        row_pos = 0;
        drain_left = 0;
        return;
      end
      colmax = max16(top_row[x], mid_row[x]);
      emit = 1'b1;
      drain_left--;
    end
    // Clip the window at the left and right edges.
    if (x == 0) begin
      res = max16(win[1], win[2]);
    end else begin
      res = max16(colmax, win[2]);
      if (x >= 2) res = max16(res, win[1]);
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2] = colmax;
    x++;
    if (x >= w) begin
      x = 0;
      if (cmd == CMD_PIXEL) begin
        row_pos++;
        if (row_pos >= h) drain_left = w + 1;
      end
    end
    col_pos = x;
    if (emit) pending_max_q.push_back('{pixel: res, frame_done: 1'b0});
  endfunction

  always @(posedge clk) begin
    max_result_t want;
    if (rst) begin
      width_reg = FRAME_WIDTH_BITS'(RESET_FRAME_WIDTH);
      height_reg = FRAME_HEIGHT_BITS'(RESET_FRAME_HEIGHT);
      win = '{default: '0};
      col_pos = 0;
      row_pos = 0;
      drain_left = 0;
      err_cnt = 0;
      pending_max_q.delete();
    end else begin
      // Any write to a real register restarts the frame.
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data[FRAME_WIDTH_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
            drain_left = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data[FRAME_HEIGHT_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
            drain_left = 0;
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) dilate_item(s_axis_tuser, s_axis_tdata);
      // Compare each result with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_max_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mf3x3_checker: %0t unexpected result pixel=%h last=%b",
                     $realtime, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_max_q.pop_front();
          if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.frame_done) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mf3x3_checker: %0t expected pixel=%h last=%b, got pixel=%h last=%b",
                       $realtime, want.pixel, want.frame_done, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
    errors <= err_cnt;
    outstanding <= pending_max_q.size();
  end

endmodule

/* verif/tb_max_filter_3x3.sv */
// Testbench top for the 3x3 maximum filter: drives frames of random pixels,
// drain ticks and register writes with random idling on both streams.
// Depends on mf3x3_pkg, max_filter_3x3 and mf3x3_checker.
`timescale 1ns / 1ps

module tb_max_filter_3x3;

  import mf3x3_pkg::*;

  localparam int SETTLE       = 10;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAXW         = DEF_MAX_WIDTH;

  // Register indexes that exist on the port but select nothing.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [DATA_BITS-1:0]      s_axis_tdata;   // [15:0] pixel_in
  logic                      s_axis_tuser;   // [0] cmd
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [DATA_BITS-1:0]      m_axis_tdata;   // [15:0] pixel_out
  logic                      m_axis_tlast;   // frame_done
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        errors;
  int                        outstanding;

  // Sender pacing state and the receiver hold-off request.
  bit tx_calm;
  int tx_left;
  bit burst;
  int hold_len;

  max_filter_3x3 DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mf3x3_checker #(.MAX_WIDTH(MAXW)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #100_000_000;
    $display("tb_max_filter_3x3: FAIL");
    $finish;
  end

  // Output side: random stalls, calm stretches, and long hold-offs on request.
  initial begin : receiver
    int stall;
    int stretch;
    bit calm;
    m_axis_tready = 1'b0;
    stall = 0;
    stretch = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        stretch = $urandom_range(50, 300);
      end
      stretch--;
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else if (stall == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [DATA_BITS-1:0] pick_pixel(input bit narrow);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return narrow ? 16'h00FF : 16'hFFFF;
    return narrow ? 16'($urandom_range(0, 255)) : 16'($urandom);
  endfunction

  // Offers one item after a random gap and returns at the edge it is taken.
  task automatic send_item(input logic cmd, input logic [DATA_BITS-1:0] pix);
    int gap;
    int r;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(50, 300);
    end
    tx_left--;
    gap = 0;
    if (!burst && !tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= pix;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both size registers once idle and returns the sizes in effect.
  task automatic set_frame(input logic [CFG_DATA_BITS-1:0] wval,
                           input logic [CFG_DATA_BITS-1:0] hval,
                           output int ew, output int eh);
    wait_idle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_FRAME_WIDTH, wval);
      write_reg(REG_FRAME_HEIGHT, hval);
    end else begin
      write_reg(REG_FRAME_HEIGHT, hval);
      write_reg(REG_FRAME_WIDTH, wval);
    end
    if ($urandom_range(0, 4) == 0)
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    ew = int'(wval[FRAME_WIDTH_BITS-1:0]);
    if (ew < 2) ew = 2;
    if (ew > MAXW) ew = MAXW;
    eh = (hval < 2) ? 2 : int'(hval);
  endtask

  // One frame: w*h pixels then w+1 drain ticks, cut short at stop_at items.
  // Now and then an item that the block must ignore slips in.
  task automatic run_frame(input int w, input int h, input int stop_at, input bit narrow);
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_item((i < w * h) ? CMD_DRAIN : CMD_PIXEL, pick_pixel(narrow));
      if ($urandom_range(0, 199) == 0) wait_idle();
      send_item((i < w * h) ? CMD_PIXEL : CMD_DRAIN, pick_pixel(narrow));
    end
  endtask

  initial begin : stimulus
    int ew;
    int eh;
    int total;
    int frames;
    int stop_at;
    int done_items;
    int waited;
    bit narrow;
    logic [CFG_DATA_BITS-1:0] wval;
    logic [CFG_DATA_BITS-1:0] hval;
    logic [DATA_BITS-1:0] corner_vals [9];
    corner_vals = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001,
                    16'h8000, 16'h0000, 16'h1234, 16'hFFFE};
    tx_calm = 1'b0;
    tx_left = 0;
    burst = 1'b0;
    hold_len = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_PIXEL;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a drain tick with nothing pending, then a 3x3 frame of
    // extreme values with spare-register writes in the middle of it,
    // a pixel during the drain and a drain tick after the frame ends.
    send_item(CMD_DRAIN, 16'hFFFF);
    set_frame(16'd3, 16'd3, ew, eh);
    for (int i = 0; i < 9; i++) begin
      send_item(CMD_PIXEL, corner_vals[i]);
      if (i == 3) begin
        wait_idle();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'hFFFF);
      end
    end
    send_item(CMD_PIXEL, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 16'h0000);
    send_item(CMD_DRAIN, 16'h0000);

    // The receiver holds off for a long stretch while items keep coming.
    set_frame(16'd12, 16'd6, ew, eh);
    burst = 1'b1;
    hold_len = 300;
    run_frame(ew, eh, ew * eh + ew + 1, 1'b0);
    burst = 1'b0;

    // Random frames of small sizes, sometimes cut short by a new setting.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       wval = 16'($urandom_range(0, 1));
        1:       wval = 16'd2;
        2:       wval = (16'($urandom_range(1, 7)) << 13) | 16'($urandom_range(2, 9));
        3:       wval = 16'($urandom_range(13, 40));
        default: wval = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 6))
        0:       hval = 16'($urandom_range(0, 1));
        1:       hval = 16'($urandom_range(7, 12));
        default: hval = 16'($urandom_range(2, 6));
      endcase
      set_frame(wval, hval, ew, eh);
      frames = $urandom_range(1, 3);
      narrow = ($urandom_range(0, 3) == 0);
      for (int f = 0; f < frames; f++) begin
        total = ew * eh + ew + 1;
        stop_at = (f == frames - 1 && $urandom_range(0, 6) == 0) ?
                  $urandom_range(1, total - 1) : total;
        run_frame(ew, eh, stop_at, narrow);
        done_items += stop_at;
      end
    end

    // A clamped width and the tallest height, stopped early in the first row.
    set_frame(16'hFFFF, 16'hFFFF, ew, eh);
    run_frame(ew, eh, 40, 1'b0);
    s_axis_tvalid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < 100000);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_max_filter_3x3: PASS");
    end else begin
      $display("tb_max_filter_3x3: FAIL");
    end
    $finish;
  end

endmodule
